// File: rtl/core/msc_pkg.sv
// mesh subset compaction package: sizes, command codes and item types
// used by the channel interfaces and the compaction core
`timescale 1ns / 1ps
package msc_pkg;

	// vertex store depth and derived widths
	localparam int MAX_VERTICES = 4096;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W = 12;
	localparam int ID_W = 12;
	localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	// command codes of an input item
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_VERTEX = 2'd1,
		CMD_FACE   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic             selected;
		logic [IDX_W-1:0] corner_a;
		logic [IDX_W-1:0] corner_b;
		logic [IDX_W-1:0] corner_c;
	} in_item_t;

	typedef struct packed {
		logic            is_face;
		logic            kept;
		logic [ID_W-1:0] new_a;
		logic [ID_W-1:0] new_b;
		logic [ID_W-1:0] new_c;
		logic            overflow;
	} out_item_t;

	// one stored vertex entry
	typedef struct packed {
		logic            kept;
		logic [ID_W-1:0] id;
	} vtx_word_t;

endpackage

// File: rtl/core/msc_ifs.sv
// valid/ready channel interfaces of the mesh subset compaction block
// depends on msc_pkg for the item types
`timescale 1ns / 1ps

// input item channel
interface msc_in_if import msc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface msc_out_if import msc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// register write channel
interface msc_cfg_if ();
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mesh_subset_compaction.sv
// mesh subset compaction core: vertex store, counters and face remap
// depends on msc_pkg and the channel interfaces in msc_ifs
`timescale 1ns / 1ps
//
// Usage: items enter on in_ch (valid/ready). A start item zeroes the vertex
// counters and gives no result. Vertex items are numbered in arrival order;
// each returns one result on out_ch with its kept flag and compacted id, or
// overflow when the store already holds MAX_VERTICES vertices. Face items
// return a remapped face only when they pass the corner test set by the
// register on cfg (1: all corners kept, 0: any corner kept and all ids
// nonzero). The register is written whenever cfg valid is high.
// A vertex result appears on out_ch the cycle after acceptance. A face
// goes through S_RD_B, S_RD_C and S_LAST, and no new item is taken
// meanwhile: its three corners are read one after another through the
// single read port of the vertex memory, then S_LAST judges the face.
// Entries at or above the vertex count read as not kept, so neither reset
// nor a start item sweeps the memory; reset clears counters, the register
// (to all-corners mode) and the output register and the block is ready at
// once. A stalled receiver holds the result in the output register; the
// next item is taken as soon as that register is free or being emptied.
//
module mesh_subset_compaction import msc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	msc_in_if.sink     in_ch,
	msc_out_if.source  out_ch,
	msc_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_B,
		S_RD_C,
		S_LAST
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   seen_q;
	logic [CNT_W-1:0]   kept_cnt_q;
	logic               all_mode_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	logic [IDX_W-1:0]   corner_b_q;
	logic [IDX_W-1:0]   corner_c_q;
	logic [2:0]         loaded_q;
	vtx_word_t          word_a_q;
	vtx_word_t          word_b_q;

	vtx_word_t          mem [MAX_VERTICES];
	vtx_word_t          rd_data_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	vtx_word_t          wr_data;

	logic               out_free;
	logic               in_acc;
	logic               is_full;
	logic               face_go;
	logic               fa, fb, fc;
	logic [ID_W-1:0]    ia, ib, ic;
	logic               emit;
	logic [2:0]         loaded_d;
	logic               out_load;
	out_item_t          out_next;

	// handshakes
	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = (state_q == S_IDLE) && out_free;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	assign is_full = (seen_q == CNT_W'(MAX_VERTICES));
	assign face_go = in_acc && (in_ch.data.cmd == CMD_FACE);

	// corner loaded checks against the vertex count at face acceptance
	assign loaded_d[0] = CMP_W'(in_ch.data.corner_a) < CMP_W'(seen_q);
	assign loaded_d[1] = CMP_W'(in_ch.data.corner_b) < CMP_W'(seen_q);
	assign loaded_d[2] = CMP_W'(in_ch.data.corner_c) < CMP_W'(seen_q);

	// vertex store write on every vertex item that fits
	assign wr_en        = in_acc && (in_ch.data.cmd == CMD_VERTEX) && !is_full;
	assign wr_data.kept = in_ch.data.selected;
	assign wr_data.id   = in_ch.data.selected ? ID_W'(kept_cnt_q) : '0;

	// read port sequencing: one corner per cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(in_ch.data.corner_a);
		unique case (state_q)
			S_IDLE: begin
				rd_en   = face_go;
				rd_addr = ADDR_W'(in_ch.data.corner_a);
			end
			S_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(corner_b_q);
			end
			S_RD_C: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(corner_c_q);
			end
			S_LAST: begin
				rd_en   = 1'b0;
				rd_addr = ADDR_W'(corner_c_q);
			end
			default: begin
				rd_en   = 1'b0;
			end
		endcase
	end

	// vertex memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ADDR_W'(seen_q)] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// face test on the three looked-up corners
	always_comb begin
		fa = loaded_q[0] && word_a_q.kept;
		fb = loaded_q[1] && word_b_q.kept;
		fc = loaded_q[2] && rd_data_q.kept;
		ia = loaded_q[0] ? word_a_q.id : '0;
		ib = loaded_q[1] ? word_b_q.id : '0;
		ic = loaded_q[2] ? rd_data_q.id : '0;
		if (all_mode_q) begin
			emit = fa && fb && fc;
		end else begin
			emit = (fa || fb || fc) && (ia != '0) && (ib != '0) && (ic != '0);
		end
	end

	// next result item: vertex reply or remapped face
	always_comb begin
		out_load = 1'b0;
		out_next = '0;
		if (state_q == S_LAST) begin
			out_load         = emit && out_free;
			out_next.is_face = 1'b1;
			out_next.new_a   = ia;
			out_next.new_b   = ib;
			out_next.new_c   = ic;
		end else if (in_acc && (in_ch.data.cmd == CMD_VERTEX)) begin
			out_load          = 1'b1;
			out_next.overflow = is_full;
			if (!is_full && in_ch.data.selected) begin
				out_next.kept  = 1'b1;
				out_next.new_a = ID_W'(kept_cnt_q);
			end
		end
	end

	// control, counters, register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			kept_cnt_q  <= '0;
			all_mode_q  <= 1'b1;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			corner_b_q  <= '0;
			corner_c_q  <= '0;
			loaded_q    <= '0;
			word_a_q    <= '0;
			word_b_q    <= '0;
		end else begin
			if (cfg.valid) begin
				all_mode_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= out_next;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_ch.data.cmd)
							CMD_START: begin
								seen_q     <= '0;
								kept_cnt_q <= '0;
							end
							CMD_VERTEX: begin
								if (!is_full) begin
									seen_q <= seen_q + 1'b1;
									if (in_ch.data.selected) begin
										kept_cnt_q <= kept_cnt_q + 1'b1;
									end
								end
							end
							CMD_FACE: begin
								corner_b_q <= in_ch.data.corner_b;
								corner_c_q <= in_ch.data.corner_c;
								loaded_q   <= loaded_d;
								state_q    <= S_RD_B;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_B: begin
					word_a_q <= rd_data_q;
					state_q  <= S_RD_C;
				end
				S_RD_C: begin
					word_b_q <= rd_data_q;
					state_q  <= S_LAST;
				end
				S_LAST: begin
					if (!emit || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// kept count never passes the vertex count
	a_kept_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= seen_q)
		else $error("kept count above vertex count");

	// vertex count stays within the store
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	// no store write while a face lookup is running
	a_no_write_in_face: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IDLE))
		else $error("store written during face lookup");

	// a vertex item always gives a result in the next cycle
	a_vertex_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_ch.data.cmd == CMD_VERTEX)) |=>
		(out_valid_q && !out_data_q.is_face))
		else $error("vertex result missing");

	// a face result only leaves the last lookup state
	a_face_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.is_face && !$past(out_valid_q && out_data_q.is_face))
		|-> ($past(state_q) == S_LAST))
		else $error("face result without lookup");

endmodule
